@@ src/cclx_pkg.sv @@
// Shared types, character codes and byte-set helpers for the content line lexer.
// No dependencies; used by the lexer top level and its port checker.
package cclx_pkg;

  typedef enum logic [3:0] {
    CL_LNAME = 4'd0,
    CL_PNAME = 4'd1,
    CL_PVAL  = 4'd2,
    CL_LVAL  = 4'd3,
    CL_SEMI  = 4'd4,
    CL_EQ    = 4'd5,
    CL_COMMA = 4'd6,
    CL_COLON = 4'd7,
    CL_QUOTE = 4'd8,
    CL_IGN   = 4'd9
  } class_t;

  typedef enum logic [2:0] {
    ER_NONE   = 3'd0,
    ER_LNAME  = 3'd1,
    ER_COLON  = 3'd2,
    ER_PNAME  = 3'd3,
    ER_EQUALS = 3'd4,
    ER_QUOTE  = 3'd5
  } err_t;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned ClassW = 4;
  localparam int unsigned ErrW   = 3;
  localparam int unsigned UserW  = ClassW + ErrW;

  localparam logic [7:0] CH_SEMI  = 8'h3B;  // ';'
  localparam logic [7:0] CH_COLON = 8'h3A;  // ':'
  localparam logic [7:0] CH_COMMA = 8'h2C;  // ','
  localparam logic [7:0] CH_EQ    = 8'h3D;  // '='
  localparam logic [7:0] CH_QUOTE = 8'h22;  // '"'
  localparam logic [7:0] CH_DASH  = 8'h2D;  // '-'
  localparam logic [7:0] CH_DEL   = 8'h7F;

  // 0x00-0x08, 0x0A-0x1F, DEL; tab is allowed
  function automatic logic is_control(input logic [7:0] c);
    return (c <= 8'h08) || (c >= 8'h0A && c <= 8'h1F) || (c == CH_DEL);
  endfunction

  function automatic logic is_qsafe(input logic [7:0] c);
    return !is_control(c) && (c != CH_QUOTE);
  endfunction

  function automatic logic is_safe(input logic [7:0] c);
    return is_qsafe(c) && (c != CH_SEMI) && (c != CH_COLON) && (c != CH_COMMA);
  endfunction

  function automatic logic is_name(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
           (c >= 8'h30 && c <= 8'h39) || (c == CH_DASH);
  endfunction

endpackage

@@ src/calendar_content_line_lexer.sv @@
// Top level of the calendar content line lexer: input register, lexer logic, result register.
// Depends on cclx_pkg for class/error codes and byte-set helpers.
//
// One byte of an unfolded content line (CR/LF removed) enters per beat on the s_axis side,
// with tlast on the final byte. Each byte leaves on the m_axis side after the input and result
// registers with its lexical class and the first error of the line so far; the beat flagged
// tlast carries the final line status. The block sustains one byte per clock when not stalled:
// the only loop is the lexer state (state, name-token flag, first error) updated once per byte
// by a short decode between the input and result registers. Both sides stall independently;
// a full input register holds while the result register waits for m_axis_tready. After the
// last byte of a line all lexer state returns to its reset value, so lines follow back to back.
module calendar_content_line_lexer (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] byte_in
  input  logic       s_axis_tlast,   // line_last
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] byte_out
  output logic [6:0] m_axis_tuser,   // [3:0] byte_class, [6:4] error_code
  output logic       m_axis_tlast    // line_done
);

  typedef enum logic [2:0] {
    ST_LNAME, ST_PNAME, ST_VSTART, ST_UNQ, ST_QUOTED, ST_AFTERQ, ST_LVALUE, ST_ERROR
  } state_t;

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  // result register
  logic            out_valid;
  logic [7:0]      out_byte;
  cclx_pkg::class_t out_class;
  cclx_pkg::err_t   out_err;
  logic            out_last;

  // lexer state
  state_t         state, state_next;
  logic           tok, tok_next;
  cclx_pkg::err_t ferr, ferr_next;

  cclx_pkg::class_t cls;
  cclx_pkg::err_t   err_rpt;

  logic advance;  // result register free to load this cycle
  logic take;     // input beat moves into the result register

  assign advance       = !out_valid || m_axis_tready;
  assign take          = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;

  // Per-byte decode: class and next lexer state.
  always_comb begin
    state_next = state;
    tok_next   = tok;
    ferr_next  = ferr;
    cls        = cclx_pkg::CL_IGN;
    unique case (state)
      ST_LNAME: begin
        if (cclx_pkg::is_name(in_byte)) begin
          tok_next = 1'b1;
          cls      = cclx_pkg::CL_LNAME;
        end else if (!tok) begin
          ferr_next  = cclx_pkg::ER_LNAME;
          state_next = ST_ERROR;
        end else if (in_byte == cclx_pkg::CH_SEMI) begin
          state_next = ST_PNAME;
          tok_next   = 1'b0;
          cls        = cclx_pkg::CL_SEMI;
        end else if (in_byte == cclx_pkg::CH_COLON) begin
          state_next = ST_LVALUE;
          cls        = cclx_pkg::CL_COLON;
        end else begin
          ferr_next  = cclx_pkg::ER_COLON;
          state_next = ST_ERROR;
        end
      end
      ST_PNAME: begin
        if (cclx_pkg::is_name(in_byte)) begin
          tok_next = 1'b1;
          cls      = cclx_pkg::CL_PNAME;
        end else if (!tok) begin
          ferr_next  = cclx_pkg::ER_PNAME;
          state_next = ST_ERROR;
        end else if (in_byte == cclx_pkg::CH_EQ) begin
          state_next = ST_VSTART;
          cls        = cclx_pkg::CL_EQ;
        end else begin
          ferr_next  = cclx_pkg::ER_EQUALS;
          state_next = ST_ERROR;
        end
      end
      ST_VSTART, ST_UNQ, ST_AFTERQ: begin
        if (state == ST_VSTART && in_byte == cclx_pkg::CH_QUOTE) begin
          state_next = ST_QUOTED;
          cls        = cclx_pkg::CL_QUOTE;
        end else if (state != ST_AFTERQ && cclx_pkg::is_safe(in_byte)) begin
          state_next = ST_UNQ;
          cls        = cclx_pkg::CL_PVAL;
        end else if (in_byte == cclx_pkg::CH_COMMA) begin
          state_next = ST_VSTART;
          cls        = cclx_pkg::CL_COMMA;
        end else if (in_byte == cclx_pkg::CH_SEMI) begin
          state_next = ST_PNAME;
          tok_next   = 1'b0;
          cls        = cclx_pkg::CL_SEMI;
        end else if (in_byte == cclx_pkg::CH_COLON) begin
          state_next = ST_LVALUE;
          cls        = cclx_pkg::CL_COLON;
        end else begin
          // neither a value byte nor a delimiter
          ferr_next  = cclx_pkg::ER_COLON;
          state_next = ST_ERROR;
        end
      end
      ST_QUOTED: begin
        if (cclx_pkg::is_qsafe(in_byte)) begin
          cls = cclx_pkg::CL_PVAL;
        end else if (in_byte == cclx_pkg::CH_QUOTE) begin
          state_next = ST_AFTERQ;
          cls        = cclx_pkg::CL_QUOTE;
        end else begin
          ferr_next  = cclx_pkg::ER_QUOTE;
          state_next = ST_ERROR;
        end
      end
      ST_LVALUE: cls = cclx_pkg::CL_LVAL;  // everything after ':' is value
      ST_ERROR:  cls = cclx_pkg::CL_IGN;
      default:   state_next = ST_ERROR;
    endcase
  end

  // Status reported with the byte: running first error, or end-of-line check on the last byte.
  always_comb begin
    err_rpt = ferr_next;
    if (in_last) begin
      unique case (state_next)
        ST_LVALUE: err_rpt = cclx_pkg::ER_NONE;
        ST_PNAME:  err_rpt = tok_next ? cclx_pkg::ER_EQUALS : cclx_pkg::ER_PNAME;
        ST_QUOTED: err_rpt = cclx_pkg::ER_QUOTE;
        ST_ERROR:  err_rpt = ferr_next;
        default:   err_rpt = cclx_pkg::ER_COLON;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      state     <= ST_LNAME;
      tok       <= 1'b0;
      ferr      <= cclx_pkg::ER_NONE;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
        in_byte  <= s_axis_tdata;
        in_last  <= s_axis_tlast;
      end
      if (advance) begin
        out_valid <= in_valid;
      end
      if (take) begin
        out_byte  <= in_byte;
        out_class <= cls;
        out_err   <= err_rpt;
        out_last  <= in_last;
        // a finished line leaves the lexer as after reset
        state     <= in_last ? ST_LNAME : state_next;
        tok       <= in_last ? 1'b0 : tok_next;
        ferr      <= in_last ? cclx_pkg::ER_NONE : ferr_next;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_byte;
  assign m_axis_tuser  = {out_err, out_class};
  assign m_axis_tlast  = out_last;

endmodule

@@ src/cclx_checker.sv @@
// Port-level checker for the content line lexer, bound to the top level.
// Depends on cclx_pkg for class and error codes.
module cclx_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [6:0] m_axis_tuser,
  input logic       m_axis_tlast
);

  logic       beat;
  logic       err_seen;  // an earlier beat of this line raised an error
  logic [2:0] err_held;

  assign beat = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      err_seen <= 1'b0;
      err_held <= 3'd0;
    end else if (beat) begin
      err_seen <= !m_axis_tlast && (m_axis_tuser[3:0] == cclx_pkg::CL_IGN);
      err_held <= m_axis_tuser[6:4];
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_ign_has_err: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser[3:0] == cclx_pkg::CL_IGN) |-> (m_axis_tuser[6:4] != 3'd0))
    else $error("ignored byte without an error code");

  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && err_seen |->
      (m_axis_tuser[3:0] == cclx_pkg::CL_IGN) && (m_axis_tuser[6:4] == err_held))
    else $error("first error not kept for the rest of the line");

endmodule

bind calendar_content_line_lexer cclx_checker u_cclx_checker (.*);
